// ----- rtl/wtsp_pkg.sv -----
package wtsp_pkg;

  localparam int unsigned CoefW  = 32;
  localparam int unsigned PosW   = 32;
  localparam int unsigned ScrW   = 16;
  localparam int unsigned ProdW  = CoefW + PosW;
  localparam int unsigned FracSh = 24;
  localparam int unsigned DotW   = 42;
  localparam int unsigned DenW   = DotW + 1;
  localparam int unsigned NumW   = 62;
  localparam int unsigned MagW   = NumW - 1;
  localparam int unsigned QuoW   = 16;
  localparam int unsigned RemW   = DenW + 1;
  localparam int unsigned NumRegs = 7;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 64;

  localparam logic signed [DotW-1:0] WThreshold = DotW'(66);

  localparam logic [CfgIdxW-1:0] RegRow0A  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRow0B  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRow1A  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRow1B  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRow3A  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRow3B  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegScreen = 3'd6;

  typedef logic signed [CoefW-1:0] coef_t;

  // rows: 0 -> clip x, 1 -> clip y, 2 -> depth
  typedef struct packed {
    coef_t [2:0][3:0] m;
    logic [ScrW-1:0]  wd;
    logic [ScrW-1:0]  ht;
  } cfg_t;

  typedef struct packed {
    logic signed [DotW-1:0] w;
    logic signed [DotW-1:0] cx;
    logic signed [DotW-1:0] cy;
  } clip_t;

  typedef struct packed {
    logic            vis;
    logic            neg;
    logic [MagW-1:0] mag;
    logic [DenW-1:0] den;
  } job_t;

endpackage

// ----- rtl/wtsp_if.sv -----
interface point_if;
  import wtsp_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [PosW-1:0] pos_x;
  logic signed [PosW-1:0] pos_y;
  logic signed [PosW-1:0] pos_z;
  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface screen_if;
  import wtsp_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   visible;
  logic signed [ScrW-1:0] screen_x;
  logic signed [ScrW-1:0] screen_y;
  modport source (output valid, visible, screen_x, screen_y, input ready);
  modport sink (input valid, visible, screen_x, screen_y, output ready);
endinterface

// ----- rtl/world_to_screen_projection.sv -----
// Projects one world point (x, y, z in signed Q16.16) per beat to screen
// coordinates using rows 0, 1 and 3 of a Q8.24 view-projection matrix and the
// screen size held in seven write-only registers. A new point is taken every
// cycle while the output is not stalled; each result passes through the
// two stages of the matrix dot products, two stages of the viewport scaling
// and the 18 stages of the bit-per-stage divider. A stall at the output holds
// the whole pipeline. Points with depth at or below 0.001 come out with
// visible low and zero coordinates; coordinates saturate to signed 16 bits.
module world_to_screen_projection import wtsp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  point_if.sink              in_pt,
  screen_if.source           out_scr
);

  logic [CfgW-1:0]   pair_q [6];
  logic [2*ScrW-1:0] scr_q;
  cfg_t              cfg;
  logic              en;
  logic              v_dot, v_map, v_x, v_y, vis_x, vis_y;
  clip_t             clip;
  job_t              job_x, job_y;
  logic signed [ScrW-1:0] res_x, res_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        pair_q[i] <= '0;
      end
      scr_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegRow0A:  pair_q[0] <= cfg_data_i;
        RegRow0B:  pair_q[1] <= cfg_data_i;
        RegRow1A:  pair_q[2] <= cfg_data_i;
        RegRow1B:  pair_q[3] <= cfg_data_i;
        RegRow3A:  pair_q[4] <= cfg_data_i;
        RegRow3B:  pair_q[5] <= cfg_data_i;
        RegScreen: scr_q     <= cfg_data_i[2*ScrW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      cfg.m[r][0] = pair_q[2*r][CoefW-1:0];
      cfg.m[r][1] = pair_q[2*r][CfgW-1:CoefW];
      cfg.m[r][2] = pair_q[2*r+1][CoefW-1:0];
      cfg.m[r][3] = pair_q[2*r+1][CfgW-1:CoefW];
    end
    cfg.wd = scr_q[ScrW-1:0];
    cfg.ht = scr_q[2*ScrW-1:ScrW];
  end

  assign en           = !v_x || out_scr.ready;
  assign in_pt.ready  = en;

  wtsp_dot u_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_pt.valid),
    .cfg_i   (cfg),
    .pos_x_i (in_pt.pos_x),
    .pos_y_i (in_pt.pos_y),
    .pos_z_i (in_pt.pos_z),
    .valid_o (v_dot),
    .clip_o  (clip)
  );

  wtsp_map u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_dot),
    .clip_i  (clip),
    .wd_i    (cfg.wd),
    .ht_i    (cfg.ht),
    .valid_o (v_map),
    .job_x_o (job_x),
    .job_y_o (job_y)
  );

  wtsp_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_map),
    .job_i   (job_x),
    .valid_o (v_x),
    .vis_o   (vis_x),
    .res_o   (res_x)
  );

  wtsp_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_map),
    .job_i   (job_y),
    .valid_o (v_y),
    .vis_o   (vis_y),
    .res_o   (res_y)
  );

  assign out_scr.valid    = v_x;
  assign out_scr.visible  = vis_x;
  assign out_scr.screen_x = res_x;
  assign out_scr.screen_y = res_y;

`ifndef ASSERT_OFF
  a_lanes_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_x == v_y) && (!v_x || (vis_x == vis_y)))
    else $error("x and y lanes out of step");

  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_scr.valid && !out_scr.visible) |->
      (out_scr.screen_x == '0) && (out_scr.screen_y == '0))
    else $error("hidden point with non-zero coordinates");

  a_stall_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_scr.valid && !out_scr.ready) |-> !in_pt.ready)
    else $error("beat taken while output stalled");
`endif

endmodule

// ----- rtl/wtsp_dot.sv -----
module wtsp_dot import wtsp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  cfg_t                   cfg_i,
  input  logic signed [PosW-1:0] pos_x_i,
  input  logic signed [PosW-1:0] pos_y_i,
  input  logic signed [PosW-1:0] pos_z_i,
  output logic                   valid_o,
  output clip_t                  clip_o
);

  logic signed [PosW-1:0]  pt [3];
  logic signed [ProdW-1:0] prod_q [3][3];
  logic signed [CoefW-9:0] c3_q [3];
  logic signed [DotW-1:0]  sum_d [3];
  logic                    v1_q, v2_q;
  clip_t                   clip_q;

  assign pt[0] = pos_x_i;
  assign pt[1] = pos_y_i;
  assign pt[2] = pos_z_i;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_d[r] = DotW'($signed(prod_q[r][0][ProdW-1:FracSh]))
               + DotW'($signed(prod_q[r][1][ProdW-1:FracSh]))
               + DotW'($signed(prod_q[r][2][ProdW-1:FracSh]))
               + DotW'(c3_q[r]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod_q[r][k] <= ProdW'(cfg_i.m[r][k]) * ProdW'(pt[k]);
        end
        c3_q[r] <= $signed(cfg_i.m[r][3][CoefW-1:8]);
      end
      clip_q.cx <= sum_d[0];
      clip_q.cy <= sum_d[1];
      clip_q.w  <= sum_d[2];
    end
  end

  assign valid_o = v2_q;
  assign clip_o  = clip_q;

endmodule

// ----- rtl/wtsp_map.sv -----
module wtsp_map import wtsp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  clip_t           clip_i,
  input  logic [ScrW-1:0] wd_i,
  input  logic [ScrW-1:0] ht_i,
  output logic            valid_o,
  output job_t            job_x_o,
  output job_t            job_y_o
);

  logic                   v3_q, v4_q;
  logic                   vis_q;
  logic [DenW-1:0]        den_q;
  logic signed [NumW-1:0] w_q, ax_q, bx_q, ay_q, by_q;
  logic signed [NumW-1:0] numx_d, numy_d;
  job_t                   jx_q, jy_q;

  always_comb begin
    numx_d = ax_q + bx_q + w_q;
    numy_d = ay_q - by_q - w_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= valid_i;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vis_q <= clip_i.w > WThreshold;
      den_q <= {clip_i.w[DotW-1:0], 1'b0};
      w_q   <= NumW'(clip_i.w);
      ax_q  <= NumW'($signed({1'b0, clip_i.w, 1'b0}) *
                     $signed({2'b00, wd_i[ScrW-1:1]}));
      ay_q  <= NumW'($signed({1'b0, clip_i.w, 1'b0}) *
                     $signed({2'b00, ht_i[ScrW-1:1]}));
      bx_q  <= NumW'(clip_i.cx * $signed({1'b0, wd_i}));
      by_q  <= NumW'(clip_i.cy * $signed({1'b0, ht_i}));
      jx_q.vis <= vis_q;
      jx_q.den <= den_q;
      jx_q.neg <= numx_d[NumW-1];
      jx_q.mag <= numx_d[NumW-1] ? MagW'(-numx_d) : MagW'(numx_d);
      jy_q.vis <= vis_q;
      jy_q.den <= den_q;
      jy_q.neg <= numy_d[NumW-1];
      jy_q.mag <= numy_d[NumW-1] ? MagW'(-numy_d) : MagW'(numy_d);
    end
  end

  assign valid_o = v4_q;
  assign job_x_o = jx_q;
  assign job_y_o = jy_q;

endmodule

// ----- rtl/wtsp_div.sv -----
module wtsp_div import wtsp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  job_t                   job_i,
  output logic                   valid_o,
  output logic                   vis_o,
  output logic signed [ScrW-1:0] res_o
);

  typedef struct packed {
    logic            vis;
    logic            neg;
    logic            ovf;
    logic [RemW-1:0] rem;
    logic [QuoW-1:0] low;
    logic [QuoW-1:0] quo;
    logic [DenW-1:0] den;
  } step_t;

  step_t                  st_q [QuoW+1];
  step_t                  st_d [QuoW+1];
  logic [QuoW:0]          v_q;
  logic                   vo_q;
  logic                   vis_q;
  logic signed [ScrW-1:0] res_q;
  logic signed [ScrW-1:0] res_d;
  step_t                  fin;

  always_comb begin
    st_d[0].vis = job_i.vis;
    st_d[0].neg = job_i.neg;
    st_d[0].den = job_i.den;
    st_d[0].ovf = job_i.mag >= MagW'({job_i.den, {QuoW{1'b0}}});
    st_d[0].rem = RemW'(job_i.mag[MagW-1:QuoW]);
    st_d[0].low = job_i.mag[QuoW-1:0];
    st_d[0].quo = '0;
  end

  for (genvar k = 1; k <= QuoW; k++) begin : g_step
    logic [RemW-1:0] t;
    always_comb begin
      t        = {st_q[k-1].rem[RemW-2:0], st_q[k-1].low[QuoW-1]};
      st_d[k]  = st_q[k-1];
      st_d[k].low = {st_q[k-1].low[QuoW-2:0], 1'b0};
      if (t >= RemW'(st_q[k-1].den)) begin
        st_d[k].rem = t - RemW'(st_q[k-1].den);
        st_d[k].quo = {st_q[k-1].quo[QuoW-2:0], 1'b1};
      end else begin
        st_d[k].rem = t;
        st_d[k].quo = {st_q[k-1].quo[QuoW-2:0], 1'b0};
      end
    end
  end

  assign fin = st_q[QuoW];

  always_comb begin
    if (!fin.vis) begin
      res_d = '0;
    end else if (fin.ovf) begin
      res_d = fin.neg ? {1'b1, {(ScrW-1){1'b0}}} : {1'b0, {(ScrW-1){1'b1}}};
    end else if (fin.neg) begin
      if (fin.quo > {1'b1, {(QuoW-1){1'b0}}}) begin
        res_d = {1'b1, {(ScrW-1){1'b0}}};
      end else begin
        res_d = ScrW'(-fin.quo);
      end
    end else if (fin.quo[QuoW-1]) begin
      res_d = {1'b0, {(ScrW-1){1'b1}}};
    end else begin
      res_d = $signed(fin.quo);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      v_q  <= {v_q[QuoW-1:0], valid_i};
      vo_q <= v_q[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k <= QuoW; k++) begin
        st_q[k] <= st_d[k];
      end
      vis_q <= fin.vis;
      res_q <= res_d;
    end
  end

  assign valid_o = vo_q;
  assign vis_o   = vis_q;
  assign res_o   = res_q;

endmodule
